### rtl/core/pot_jog_position_ramp_defines.svh
// Assertion macros shared by the pot jog position ramp RTL.
// Depends on nothing; the asserting module provides clk and rst.
`ifndef POT_JOG_POSITION_RAMP_DEFINES_SVH
`define POT_JOG_POSITION_RAMP_DEFINES_SVH

`ifndef ASSERT_OFF
`define PJR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define PJR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define PJR_ASSERT_SAME(lbl, ante, cons, msg)
`define PJR_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### rtl/core/pjr_pkg.sv
// Package for the pot jog position ramp: field widths, register map,
// reset values and fixed-point constants. Depends on nothing.
package pjr_pkg;

  localparam int READ_W   = 10;
  localparam int TIME_W   = 32;
  localparam int DELTA_W  = 11;
  localparam int DIR_W    = 2;
  localparam int DELAY_W  = 16;
  localparam int LIMIT_W  = 9;
  localparam int IVAL_W   = 24;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 24;

  localparam int WINDOW_DEF = 5;

  localparam logic [LIMIT_W-1:0] END_LIMIT_RST   = 9'd396;
  localparam logic [LIMIT_W-1:0] JITTER_RST      = 9'd2;
  localparam logic [IVAL_W-1:0]  RAMP_IVAL_RST   = 24'd25000;
  localparam logic [DELAY_W-1:0] INIT_DELAY_RST  = 16'd16192;

  // floor(d * 20 / 21) == (d * DELAY_MUL_C) >> DELAY_MUL_K for every 16-bit d.
  localparam int DELAY_MUL_K = 22;
  localparam logic [DELAY_MUL_K-1:0] DELAY_MUL_C = 22'd3994576;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_END_LIMIT  = 8'd0,
    REG_JITTER     = 8'd1,
    REG_RAMP_IVAL  = 8'd2,
    REG_INIT_DELAY = 8'd3
  } cfg_reg_t;

endpackage

### rtl/core/pjr_in_if.sv
// Input channel of the pot jog position ramp: one reading and its timestamp.
// Depends on pjr_pkg.
interface pjr_in_if;
  import pjr_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [READ_W-1:0] reading;
  logic [TIME_W-1:0]        now_us;

  modport source(output valid, reading, now_us, input ready);
  modport sink(input valid, reading, now_us, output ready);
endinterface

### rtl/core/pjr_out_if.sv
// Result channel of the pot jog position ramp.
// Depends on pjr_pkg.
interface pjr_out_if;
  import pjr_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [DELTA_W-1:0] step_delta;
  logic signed [DIR_W-1:0]   direction;
  logic [DELAY_W-1:0]        delay_us;
  logic                      moving;
  logic signed [READ_W-1:0]  target;

  modport source(output valid, step_delta, direction, delay_us, moving, target, input ready);
  modport sink(input valid, step_delta, direction, delay_us, moving, target, output ready);
endinterface

### rtl/core/pjr_cfg_if.sv
// Configuration write channel of the pot jog position ramp.
// Depends on pjr_pkg.
interface pjr_cfg_if;
  import pjr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

### rtl/core/pot_jog_position_ramp.sv
// A result passes through the stage B, C and D registers and the result register (read, sum, divide, decide).
// Throughput: one item per cycle while the result register is not stalled; the sample ring memory is read when an item
// is taken and written back when that item leaves stage B, with forwarding when both touch the same slot.
// Back-pressure on the result register stalls the whole pipeline in place.
// Reset (rst, synchronous): empties the pipeline, clears the ring valid bits, sum, target and
// moving state, and returns the registers to their default values. No clearing pass.
`include "pot_jog_position_ramp_defines.svh"

module pot_jog_position_ramp #(
  parameter int WINDOW = pjr_pkg::WINDOW_DEF
) (
  input  logic         clk,
  input  logic         rst,
  pjr_in_if.sink       in,
  pjr_out_if.source    out,
  pjr_cfg_if.sink      cfg
);
  import pjr_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int SUM_W  = READ_W + $clog2(WINDOW);
  localparam int DIV_K  = SUM_W + $clog2(WINDOW) + 1;
  localparam logic [DIV_K:0] RECIP = (DIV_K+1)'(((64'd1 << DIV_K) + WINDOW - 1) / WINDOW);
  localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(WINDOW - 1);

  // Configuration registers.
  logic [LIMIT_W-1:0] end_limit;
  logic [LIMIT_W-1:0] jitter_threshold;
  logic [IVAL_W-1:0]  ramp_interval_us;
  logic [DELAY_W-1:0] initial_delay_us;

  // Sample ring memory and its valid bits.
  logic signed [READ_W-1:0] ring_mem [WINDOW];
  logic [WINDOW-1:0]        ring_valid;
  logic signed [READ_W-1:0] mem_q;
  logic                     rd_valid_q;
  logic                     fwd_q;
  logic signed [READ_W-1:0] fwd_data_q;
  logic [SLOT_W-1:0]        ring_slot;

  // Running state.
  logic signed [SUM_W-1:0]  running_sum;
  logic signed [READ_W-1:0] target_position;
  logic signed [READ_W-1:0] previous_position;
  logic                     move_active;
  logic [TIME_W-1:0]        ramp_start;
  logic [DELAY_W-1:0]       step_delay;

  // Pipeline stages.
  logic                     b_valid;
  logic signed [READ_W-1:0] b_reading;
  logic [TIME_W-1:0]        b_now;
  logic [SLOT_W-1:0]        b_slot;
  logic                     c_valid;
  logic signed [SUM_W-1:0]  c_sum;
  logic signed [READ_W-1:0] c_reading;
  logic [TIME_W-1:0]        c_now;
  logic                     d_valid;
  logic signed [READ_W-1:0] d_avg;
  logic signed [READ_W-1:0] d_reading;
  logic [TIME_W-1:0]        d_now;

  // Result register.
  logic                      res_valid;
  logic signed [DELTA_W-1:0] res_delta;
  logic signed [DIR_W-1:0]   res_dir;
  logic [DELAY_W-1:0]        res_delay;
  logic                      res_moving;
  logic signed [READ_W-1:0]  res_target;

  logic en;
  logic take;
  logic wr_en;

  assign en    = !res_valid || out.ready;
  assign take  = in.valid && en;
  assign wr_en = en && b_valid;

  assign in.ready  = en;
  assign cfg.ready = 1'b1;

  assign out.valid      = res_valid;
  assign out.step_delta = res_delta;
  assign out.direction  = res_dir;
  assign out.delay_us   = res_delay;
  assign out.moving     = res_moving;
  assign out.target     = res_target;

  // ---------------- configuration ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      end_limit        <= END_LIMIT_RST;
      jitter_threshold <= JITTER_RST;
      ramp_interval_us <= RAMP_IVAL_RST;
      initial_delay_us <= INIT_DELAY_RST;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_END_LIMIT:  end_limit        <= cfg.data[LIMIT_W-1:0];
        REG_JITTER:     jitter_threshold <= cfg.data[LIMIT_W-1:0];
        REG_RAMP_IVAL:  ramp_interval_us <= cfg.data[IVAL_W-1:0];
        REG_INIT_DELAY: initial_delay_us <= cfg.data[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- ring memory ----------------
  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring_mem[b_slot] <= b_reading;
    end
    if (take) begin
      mem_q <= ring_mem[ring_slot];
    end
  end

  // A read that meets the write of the previous item at the same slot takes the new data.
  always_ff @(posedge clk) begin
    if (take) begin
      rd_valid_q <= ring_valid[ring_slot];
      fwd_q      <= wr_en && (b_slot == ring_slot);
      fwd_data_q <= b_reading;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ring_valid <= '0;
      ring_slot  <= '0;
    end else begin
      if (wr_en) begin
        ring_valid[b_slot] <= 1'b1;
      end
      if (take) begin
        ring_slot <= (ring_slot == SLOT_LAST) ? '0 : ring_slot + 1'b1;
      end
    end
  end

  // ---------------- stage B: running sum ----------------
  logic signed [READ_W-1:0] old_sample;
  logic signed [SUM_W-1:0]  sum_next;

  always_comb begin
    if (fwd_q) begin
      old_sample = fwd_data_q;
    end else if (rd_valid_q) begin
      old_sample = mem_q;
    end else begin
      old_sample = '0;
    end
    sum_next = running_sum - SUM_W'(old_sample) + SUM_W'(b_reading);
  end

  // ---------------- stage C: divide by the window ----------------
  logic                        c_neg;
  logic [SUM_W-1:0]            c_mag;
  logic [SUM_W+DIV_K:0]        c_prod;
  logic [READ_W:0]             c_quot;
  logic signed [READ_W:0]      c_avg;

  always_comb begin
    c_neg  = c_sum[SUM_W-1];
    c_mag  = c_neg ? SUM_W'(-c_sum) : SUM_W'(c_sum);
    c_prod = (SUM_W+DIV_K+1)'(c_mag) * (SUM_W+DIV_K+1)'(RECIP);
    c_quot = c_prod[DIV_K +: (READ_W+1)];
    c_avg  = c_neg ? -$signed(c_quot) : $signed(c_quot);
  end

  // ---------------- stage D: deadband, ramp and step ----------------
  logic signed [READ_W:0]    avg_diff;
  logic [READ_W:0]           avg_dist;
  logic signed [READ_W-1:0]  target_next;
  logic [READ_W-1:0]         read_mag;
  logic                      moving_now;
  logic                      entering;
  logic [TIME_W-1:0]         start_eff;
  logic [DELAY_W-1:0]        delay_eff;
  logic [TIME_W-1:0]         elapsed;
  logic                      speed_up;
  logic [DELAY_W+DELAY_MUL_K-1:0] delay_prod;
  logic [DELAY_W-1:0]        delay_dec;
  logic [DELAY_W-1:0]        delay_next;
  logic [TIME_W-1:0]         start_next;
  logic signed [DIR_W-1:0]   dir;
  logic signed [DELTA_W-1:0] delta;

  always_comb begin
    avg_diff    = (READ_W+1)'(d_avg) - (READ_W+1)'(target_position);
    avg_dist    = avg_diff[READ_W] ? (READ_W+1)'(-avg_diff) : (READ_W+1)'(avg_diff);
    target_next = (avg_dist > (READ_W+1)'(jitter_threshold)) ? d_avg : target_position;

    read_mag   = d_reading[READ_W-1] ? READ_W'(-d_reading) : READ_W'(d_reading);
    moving_now = read_mag > READ_W'(end_limit);
    entering   = moving_now && !move_active;
    start_eff  = entering ? d_now : ramp_start;
    delay_eff  = entering ? initial_delay_us : step_delay;
    elapsed    = d_now - start_eff;
    speed_up   = elapsed > TIME_W'(ramp_interval_us);

    delay_prod = (DELAY_W+DELAY_MUL_K)'(delay_eff) * (DELAY_W+DELAY_MUL_K)'(DELAY_MUL_C);
    delay_dec  = delay_prod[DELAY_MUL_K +: DELAY_W];
    if (!speed_up) begin
      delay_next = delay_eff;
    end else if (delay_dec == '0) begin
      delay_next = DELAY_W'(1);
    end else begin
      delay_next = delay_dec;
    end
    start_next = speed_up ? start_eff + TIME_W'(ramp_interval_us) : start_eff;

    if (!moving_now) begin
      dir = '0;
    end else if (target_next > 0) begin
      dir = DIR_W'(1);
    end else begin
      dir = -DIR_W'(1);
    end
    delta = DELTA_W'(target_next) + DELTA_W'(dir) - DELTA_W'(previous_position);
  end

  // ---------------- pipeline control ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      res_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= in.valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      res_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_reading <= in.reading;
      b_now     <= in.now_us;
      b_slot    <= ring_slot;
      c_sum     <= sum_next;
      c_reading <= b_reading;
      c_now     <= b_now;
      d_avg     <= c_avg[READ_W-1:0];
      d_reading <= c_reading;
      d_now     <= c_now;
      if (d_valid) begin
        res_delta  <= delta;
        res_dir    <= dir;
        res_delay  <= moving_now ? delay_next : '0;
        res_moving <= moving_now;
        res_target <= target_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum       <= '0;
      target_position   <= '0;
      previous_position <= '0;
      move_active       <= 1'b0;
      ramp_start        <= '0;
      step_delay        <= INIT_DELAY_RST;
    end else if (en) begin
      if (b_valid) begin
        running_sum <= sum_next;
      end
      if (d_valid) begin
        target_position   <= target_next;
        previous_position <= target_next;
        move_active       <= moving_now;
        if (moving_now) begin
          ramp_start <= start_next;
          step_delay <= delay_next;
        end
      end
    end
  end

  // ---------------- assertions ----------------
  `PJR_ASSERT_SAME(a_idle_result, out.valid && !out.moving, out.delay_us == '0 && out.direction == '0, "idle result carries a delay or direction")
  `PJR_ASSERT_NEXT(a_move_flag, en && d_valid, move_active == out.moving, "moving state differs from the result just issued")
  `PJR_ASSERT_NEXT(a_delay_floor, en && d_valid && moving_now && speed_up, step_delay != '0, "speed-up left a zero step delay")
  `PJR_ASSERT_NEXT(a_sum_hold, !en, $stable(running_sum) && $stable(target_position), "state moved during a stall")

endmodule
